// ===== rtl/decimal_token_lexer_top_defines.svh =====
// Assertion macros used by the checker file of the decimal token lexer.
`ifndef DECIMAL_TOKEN_LEXER_TOP_DEFINES_SVH
`define DECIMAL_TOKEN_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decimal token lexer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decimal token lexer check failed");

`endif

// ===== rtl/dtl_pkg.sv =====
// Package with the token kind codes, character codes and default widths of the lexer.
package dtl_pkg;

    // Default widths of the result fields.
    localparam int VALUE_WIDTH_DEF  = 31;
    localparam int LINE_WIDTH_DEF   = 24;
    localparam int COLUMN_WIDTH_DEF = 16;

    // Token kinds.
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Character codes the lexer reacts to.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

endpackage

// ===== rtl/dtl_if.sv =====
// Handshake interfaces for the source byte channel and the token channel.
interface dtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_input;

    modport source (output valid, output byte_in, output end_of_input, input ready);
    modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface dtl_out_if #(
    parameter int VALUE_WIDTH  = dtl_pkg::VALUE_WIDTH_DEF,
    parameter int LINE_WIDTH   = dtl_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = dtl_pkg::COLUMN_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              token_kind;
    logic [VALUE_WIDTH-1:0]  token_value;
    logic [LINE_WIDTH-1:0]   line;
    logic [COLUMN_WIDTH-1:0] column;
    logic                    last;

    modport source (output valid, output token_kind, output token_value, output line,
                    output column, output last, input ready);
    modport sink   (input valid, input token_kind, input token_value, input line,
                    input column, input last, output ready);
endinterface

// ===== rtl/dtl_in_reg.sv =====
// Input register that holds one source beat until the lexer core takes it.
module dtl_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    input  logic       i_take,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_eoi
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eoi;

    // The register accepts a new beat when empty or when its content leaves now.
    assign o_ready = !r_valid || i_take;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, loaded on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_eoi  <= i_eoi;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eoi   = r_eoi;

endmodule

// ===== rtl/dtl_core.sv =====
// Lexer core: state registers and the decode that turns one beat into up to two tokens.
module dtl_core #(
    parameter int VALUE_WIDTH  = dtl_pkg::VALUE_WIDTH_DEF,
    parameter int LINE_WIDTH   = dtl_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = dtl_pkg::COLUMN_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    output logic [1:0] o_n_res,
    output logic [1:0]              o_kind0,
    output logic [VALUE_WIDTH-1:0]  o_value0,
    output logic [LINE_WIDTH-1:0]   o_line0,
    output logic [COLUMN_WIDTH-1:0] o_column0,
    output logic                    o_last0,
    output logic [1:0]              o_kind1,
    output logic [VALUE_WIDTH-1:0]  o_value1,
    output logic [LINE_WIDTH-1:0]   o_line1,
    output logic [COLUMN_WIDTH-1:0] o_column1,
    output logic                    o_last1
);

    localparam logic [VALUE_WIDTH-1:0]  VALUE_MAX  = '1;
    localparam logic [LINE_WIDTH-1:0]   LINE_MAX   = '1;
    localparam logic [COLUMN_WIDTH-1:0] COLUMN_MAX = '1;

    logic                    r_in_number, n_in_number;
    logic [VALUE_WIDTH-1:0]  r_accum, n_accum;
    logic [LINE_WIDTH-1:0]   r_line, n_line;
    logic [COLUMN_WIDTH-1:0] r_column, n_column;
    logic                    r_halted, n_halted;

    logic                    w_is_digit;
    logic                    w_is_dot;
    logic                    w_is_blank;
    logic [3:0]              w_digit;
    logic [VALUE_WIDTH+3:0]  w_prod;
    logic [COLUMN_WIDTH-1:0] w_col_inc;
    logic                    w_has_tok;
    logic [1:0]              w_tok_kind;
    logic [VALUE_WIDTH-1:0]  w_tok_value;

    // Character classes.
    assign w_is_digit = !i_eoi && (i_byte >= dtl_pkg::CH_ZERO) && (i_byte <= dtl_pkg::CH_NINE);
    assign w_is_dot   = !i_eoi && (i_byte == dtl_pkg::CH_PERIOD);
    assign w_is_blank = !i_eoi && ((i_byte == dtl_pkg::CH_NEWLINE) ||
                                   (i_byte == dtl_pkg::CH_SPACE) ||
                                   (i_byte == dtl_pkg::CH_TAB));
    assign w_digit    = 4'(i_byte - dtl_pkg::CH_ZERO);

    // Accumulator times ten plus the digit; the top four bits flag an overflow.
    assign w_prod = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                    + (VALUE_WIDTH+4)'(w_digit);

    // Column after this beat is consumed, saturating.
    assign w_col_inc = (r_column == COLUMN_MAX) ? r_column : r_column + COLUMN_WIDTH'(1);

    // Token raised by the terminating character itself.
    always_comb begin
        w_has_tok   = 1'b0;
        w_tok_kind  = dtl_pkg::KIND_CHAR;
        w_tok_value = VALUE_WIDTH'(i_byte);
        if (i_eoi) begin
            w_has_tok   = 1'b1;
            w_tok_kind  = dtl_pkg::KIND_END;
            w_tok_value = VALUE_WIDTH'(dtl_pkg::CH_HASH);
        end else if (!w_is_blank) begin
            w_has_tok   = 1'b1;
        end
    end

    // Next state and result slots.
    always_comb begin
        n_in_number = r_in_number;
        n_accum     = r_accum;
        n_line      = r_line;
        n_column    = r_column;
        n_halted    = r_halted;
        o_n_res     = 2'd0;
        o_kind0     = w_tok_kind;
        o_value0    = w_tok_value;
        o_line0     = r_line;
        o_column0   = w_col_inc;
        o_last0     = 1'b1;
        o_kind1     = w_tok_kind;
        o_value1    = w_tok_value;
        o_line1     = r_line;
        o_column1   = w_col_inc;
        o_last1     = 1'b1;
        if (r_halted) begin
            o_n_res = 2'd0;
        end else if (w_is_digit) begin
            n_column    = w_col_inc;
            n_in_number = 1'b1;
            n_accum     = (|w_prod[VALUE_WIDTH+3:VALUE_WIDTH]) ? VALUE_MAX
                                                               : w_prod[VALUE_WIDTH-1:0];
        end else if (w_is_dot) begin
            n_column    = w_col_inc;
            n_in_number = 1'b0;
            n_accum     = '0;
            n_halted    = 1'b1;
            o_n_res     = 2'd1;
            o_kind0     = dtl_pkg::KIND_ERROR;
            o_value0    = '0;
        end else begin
            n_in_number = 1'b0;
            n_accum     = '0;
            if (!i_eoi && (i_byte == dtl_pkg::CH_NEWLINE)) begin
                n_line   = (r_line == LINE_MAX) ? r_line : r_line + LINE_WIDTH'(1);
                n_column = '0;
            end else begin
                n_column = w_col_inc;
            end
            // A pending number goes out first, at the column of its last digit.
            if (r_in_number) begin
                o_kind0   = dtl_pkg::KIND_NUMBER;
                o_value0  = r_accum;
                o_column0 = r_column;
                o_last0   = !w_has_tok;
                o_n_res   = w_has_tok ? 2'd2 : 2'd1;
            end else begin
                o_n_res   = w_has_tok ? 2'd1 : 2'd0;
            end
        end
    end

    // State registers, updated on every beat taken from the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number <= 1'b0;
            r_accum     <= '0;
            r_line      <= LINE_WIDTH'(1);
            r_column    <= '0;
            r_halted    <= 1'b0;
        end else if (i_take) begin
            r_in_number <= n_in_number;
            r_accum     <= n_accum;
            r_line      <= n_line;
            r_column    <= n_column;
            r_halted    <= n_halted;
        end
    end

endmodule

// ===== rtl/dtl_out_buf.sv =====
// Two-slot result buffer that drives the token channel.
module dtl_out_buf #(
    parameter int VALUE_WIDTH  = dtl_pkg::VALUE_WIDTH_DEF,
    parameter int LINE_WIDTH   = dtl_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = dtl_pkg::COLUMN_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [1:0] i_n_res,
    input  logic [1:0]              i_kind0,
    input  logic [VALUE_WIDTH-1:0]  i_value0,
    input  logic [LINE_WIDTH-1:0]   i_line0,
    input  logic [COLUMN_WIDTH-1:0] i_column0,
    input  logic                    i_last0,
    input  logic [1:0]              i_kind1,
    input  logic [VALUE_WIDTH-1:0]  i_value1,
    input  logic [LINE_WIDTH-1:0]   i_line1,
    input  logic [COLUMN_WIDTH-1:0] i_column1,
    input  logic                    i_last1,
    output logic       o_room,
    dtl_out_if.source  o_out
);

    typedef struct packed {
        logic [1:0]              token_kind;
        logic [VALUE_WIDTH-1:0]  token_value;
        logic [LINE_WIDTH-1:0]   line;
        logic [COLUMN_WIDTH-1:0] column;
        logic                    last;
    } t_result;

    logic [1:0] r_cnt;
    t_result    r_slot0;
    t_result    r_slot1;
    logic       w_pop;

    // A beat leaves whenever the head slot is full and the receiver is ready.
    assign w_pop  = (r_cnt != 2'd0) && o_out.ready;
    // Room for a full item means the buffer is empty after this cycle's beat leaves.
    assign o_room = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_pop);

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push) begin
            r_cnt <= i_n_res;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Slots: a push refills both, a pop moves the second slot to the head.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot0 <= '{i_kind0, i_value0, i_line0, i_column0, i_last0};
            r_slot1 <= '{i_kind1, i_value1, i_line1, i_column1, i_last1};
        end else if (w_pop) begin
            r_slot0 <= r_slot1;
        end
    end

    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.token_kind  = r_slot0.token_kind;
    assign o_out.token_value = r_slot0.token_value;
    assign o_out.line        = r_slot0.line;
    assign o_out.column      = r_slot0.column;
    assign o_out.last        = r_slot0.last;

endmodule

// ===== rtl/decimal_token_lexer_top.sv =====
// Top level of the decimal token lexer.
//
// Input channel i_in carries one source byte, or an end-of-input mark, per beat.
// Output channel o_out carries tokens: single characters, saturated decimal
// numbers, end tokens and the error token for a period, each with line, column
// and a last flag on the final token caused by an input beat.
// A token is presented on o_out once its input beat has passed the input
// register and the core has pushed its tokens into the result buffer.
// Throughput: one input beat per cycle while o_out.ready stays high. A beat
// that ends a number and also gives a token of its own produces two tokens;
// the input then pauses while the two-slot result buffer drains.
// Reset (synchronous, active low) empties both registers, sets line 1 and
// column 0, and clears the number and error states.
// When the receiver holds o_out.ready low, the token on o_out stays and the
// input register fills, after which i_in.ready drops until tokens leave.
// After a period, beats are still accepted but give no tokens until reset.
module decimal_token_lexer_top #(
    parameter int VALUE_WIDTH  = dtl_pkg::VALUE_WIDTH_DEF,
    parameter int LINE_WIDTH   = dtl_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = dtl_pkg::COLUMN_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtl_in_if.sink    i_in,
    dtl_out_if.source o_out
);

    logic                    w_take;
    logic                    w_room;
    logic                    w_reg_valid;
    logic [7:0]              w_reg_byte;
    logic                    w_reg_eoi;
    logic [1:0]              w_n_res;
    logic [1:0]              w_kind0, w_kind1;
    logic [VALUE_WIDTH-1:0]  w_value0, w_value1;
    logic [LINE_WIDTH-1:0]   w_line0, w_line1;
    logic [COLUMN_WIDTH-1:0] w_column0, w_column1;
    logic                    w_last0, w_last1;

    // The core takes the registered beat when the result buffer can hold its tokens.
    assign w_take = w_reg_valid && w_room;

    dtl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.byte_in),
        .i_eoi   (i_in.end_of_input),
        .i_take  (w_take),
        .o_ready (i_in.ready),
        .o_valid (w_reg_valid),
        .o_byte  (w_reg_byte),
        .o_eoi   (w_reg_eoi)
    );

    dtl_core #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_byte    (w_reg_byte),
        .i_eoi     (w_reg_eoi),
        .o_n_res   (w_n_res),
        .o_kind0   (w_kind0),
        .o_value0  (w_value0),
        .o_line0   (w_line0),
        .o_column0 (w_column0),
        .o_last0   (w_last0),
        .o_kind1   (w_kind1),
        .o_value1  (w_value1),
        .o_line1   (w_line1),
        .o_column1 (w_column1),
        .o_last1   (w_last1)
    );

    dtl_out_buf #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_take),
        .i_n_res   (w_n_res),
        .i_kind0   (w_kind0),
        .i_value0  (w_value0),
        .i_line0   (w_line0),
        .i_column0 (w_column0),
        .i_last0   (w_last0),
        .i_kind1   (w_kind1),
        .i_value1  (w_value1),
        .i_line1   (w_line1),
        .i_column1 (w_column1),
        .i_last1   (w_last1),
        .o_room    (w_room),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/dtl_checker.sv =====
// Port-level checker for the decimal token lexer and its bind to the top level.
`include "decimal_token_lexer_top_defines.svh"

module dtl_checker #(
    parameter int VALUE_WIDTH  = dtl_pkg::VALUE_WIDTH_DEF,
    parameter int LINE_WIDTH   = dtl_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = dtl_pkg::COLUMN_WIDTH_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [1:0]              i_kind,
    input logic [VALUE_WIDTH-1:0]  i_value,
    input logic [LINE_WIDTH-1:0]   i_line,
    input logic [COLUMN_WIDTH-1:0] i_column,
    input logic                    i_last
);

    // A stalled token holds until the receiver takes it.
    `DTL_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_value) && $stable(i_line) && $stable(i_column) && $stable(i_last))

    // Line numbers start at one and never wrap to zero.
    `DTL_ASSERT_IMP(a_line_nonzero, i_clk, i_rst_n, i_out_valid, i_line != '0)

    // The error token carries value zero and closes its beat.
    `DTL_ASSERT_IMP(a_error_form, i_clk, i_rst_n, i_out_valid && (i_kind == dtl_pkg::KIND_ERROR), (i_value == '0) && i_last)

    // The end token carries the hash code and closes its beat.
    `DTL_ASSERT_IMP(a_end_form, i_clk, i_rst_n, i_out_valid && (i_kind == dtl_pkg::KIND_END), (i_value == VALUE_WIDTH'(dtl_pkg::CH_HASH)) && i_last)

endmodule

bind decimal_token_lexer_top dtl_checker #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH)
) u_dtl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.token_kind),
    .i_value     (o_out.token_value),
    .i_line      (o_out.line),
    .i_column    (o_out.column),
    .i_last      (o_out.last)
);
